// ===== sv/rcnf_pkg.sv =====
// Shared constants and controller/datapath handshake types for the 3x3 RGB filter.
`default_nettype none
package rcnf_pkg;
  localparam int MaxWidth  = 1024;
  localparam int AddrW     = $clog2(MaxWidth);
  localparam int CoefBits  = 8;
  localparam int SumW      = 20;
  localparam int DivSteps  = SumW - 1;
  localparam int TapCnt    = 9;
  localparam int TapW      = $clog2(TapCnt);
  localparam int DivCntW   = $clog2(DivSteps + 1);
  localparam int SizeW     = 11;

  localparam logic [23:0]      KernReset   = 24'h010101;
  localparam logic [15:0]      DivReset    = 16'd9;
  localparam logic [SizeW-1:0] SizeReset   = 11'd1024;
  localparam logic [SizeW-1:0] SizeMin     = 11'd3;
  localparam logic [SizeW-1:0] SizeMax     = 11'd1024;

  // register indexes
  localparam logic [2:0] RegKernTop = 3'd0;
  localparam logic [2:0] RegKernMid = 3'd1;
  localparam logic [2:0] RegKernBot = 3'd2;
  localparam logic [2:0] RegDiv     = 3'd3;
  localparam logic [2:0] RegWidth   = 3'd4;
  localparam logic [2:0] RegHeight  = 3'd5;

  typedef struct packed {
    logic              capture;
    logic              mem_rd;
    logic              update;
    logic              mac_en;
    logic [TapW-1:0]   tap;
    logic              div_en;
    logic [DivCntW-1:0] div_step;
    logic              load_out;
  } cmd_t;

  typedef struct packed {
    logic interior;
    logic out_free;
  } stat_t;
endpackage
`default_nettype wire

// ===== sv/rgb_conv3x3_norm_filter_unit.sv =====
// Top level: APB register file plus controller and datapath of the 3x3 RGB filter.
//
// Use: RGB pixels enter in raster order on the s_axis channel (tdata = red,
// green, blue from bit 0). For every interior pixel position one filtered
// item leaves on m_axis: the per-channel true 3x3 convolution divided by the
// divisor register (truncated toward zero, zero divisor acts as one) and
// clamped to 0..255, with its row/column; tlast marks the frame's last one.
// Border pixels feed the line stores but produce no item.
// Timing: an item is taken only while the sequencer is idle. A border pixel
// passes through accept, line-store read and window update. An interior
// pixel then runs a tap-serial multiply-accumulate and a restoring divide
// (one quotient bit per cycle per channel), then the output load. The
// result sits in an output register, so the next pixel is accepted while it
// waits; if the receiver still stalls when the next interior result is ready,
// that result holds the sequencer until the register frees.
// Reset: position counters and window clear, registers take their defaults
// (all-ones kernel, divisor 9, 1024x1024). Line stores are not cleared.
// Registers are written over APB at byte address 4*index; reads return them.
`default_nettype none
module rgb_conv3x3_norm_filter_unit import rcnf_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,   // pix_red, pix_green, pix_blue
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [47:0] m_axis_tdata,   // out_red, out_green, out_blue, out_row, out_col, pad
  output logic        m_axis_tlast,   // frame_end
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  logic [23:0]      kern_q [3];
  logic [15:0]      div_q;
  logic [SizeW-1:0] width_q, height_q;

  logic [2:0]       reg_idx;
  logic             wr_en;
  logic [SizeW-1:0] size_wr;

  assign pready  = 1'b1;
  assign reg_idx = paddr[4:2];
  assign wr_en   = psel && penable && pwrite && pready;

  // clamp written frame size to 3..1024
  always_comb begin
    size_wr = pwdata[SizeW-1:0];
    if (size_wr < SizeMin) size_wr = SizeMin;
    if (size_wr > SizeMax) size_wr = SizeMax;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < 3; k++) kern_q[k] <= KernReset;
      div_q    <= DivReset;
      width_q  <= SizeReset;
      height_q <= SizeReset;
    end else if (wr_en && paddr[1:0] == 2'b00) begin
      case (reg_idx)
        RegKernTop: kern_q[0] <= pwdata[23:0];
        RegKernMid: kern_q[1] <= pwdata[23:0];
        RegKernBot: kern_q[2] <= pwdata[23:0];
        RegDiv:     div_q     <= pwdata[15:0];
        RegWidth:   width_q   <= size_wr;
        RegHeight:  height_q  <= size_wr;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      RegKernTop: prdata = {8'd0, kern_q[0]};
      RegKernMid: prdata = {8'd0, kern_q[1]};
      RegKernBot: prdata = {8'd0, kern_q[2]};
      RegDiv:     prdata = {16'd0, div_q};
      RegWidth:   prdata = {21'd0, width_q};
      RegHeight:  prdata = {21'd0, height_q};
      default:    prdata = '0;
    endcase
  end

  cmd_t  cmd;
  stat_t stat;

  rcnf_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  rcnf_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .in_valid_i  (s_axis_tvalid),
    .pix_i       (s_axis_tdata),
    .kern_i      ({kern_q[2], kern_q[1], kern_q[0]}),
    .divisor_i   (div_q),
    .width_i     (width_q),
    .height_i    (height_q),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_data_o  (m_axis_tdata),
    .out_last_o  (m_axis_tlast)
  );
endmodule
`default_nettype wire

// ===== sv/rcnf_ctrl.sv =====
// Sequencer: read, window update, tap-serial MAC, serial divide, output load.
`default_nettype none
module rcnf_ctrl import rcnf_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  in_valid_i,
  output logic  in_ready_o,
  input  stat_t stat_i,
  output cmd_t  cmd_o
);
  typedef enum logic [2:0] {
    StIdle, StRd, StUpd, StMac, StDiv, StOut
  } state_e;

  state_e             state_q, state_d;
  logic [TapW-1:0]    tap_q, tap_d;
  logic [DivCntW-1:0] div_q, div_d;

  always_comb begin
    state_d = state_q;
    tap_d   = tap_q;
    div_d   = div_q;
    case (state_q)
      StIdle: if (in_valid_i) state_d = StRd;
      StRd:   state_d = StUpd;
      StUpd: begin
        tap_d   = '0;
        state_d = stat_i.interior ? StMac : StIdle;
      end
      StMac: begin
        if (tap_q == TapW'(TapCnt - 1)) begin
          div_d   = '0;
          state_d = StDiv;
        end else begin
          tap_d = tap_q + 1'b1;
        end
      end
      StDiv: begin
        if (div_q == DivCntW'(DivSteps)) state_d = StOut;
        else div_d = div_q + 1'b1;
      end
      StOut: if (stat_i.out_free) state_d = StIdle;
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      tap_q   <= '0;
      div_q   <= '0;
    end else begin
      state_q <= state_d;
      tap_q   <= tap_d;
      div_q   <= div_d;
    end
  end

  always_comb begin
    cmd_o          = '0;
    cmd_o.capture  = (state_q == StIdle);
    cmd_o.mem_rd   = (state_q == StRd);
    cmd_o.update   = (state_q == StUpd);
    cmd_o.mac_en   = (state_q == StMac);
    cmd_o.tap      = tap_q;
    cmd_o.div_en   = (state_q == StDiv);
    cmd_o.div_step = div_q;
    cmd_o.load_out = (state_q == StOut) && stat_i.out_free;
  end
  assign in_ready_o = (state_q == StIdle);

`ifndef SYNTHESIS
  a_tap_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == StMac |-> tap_q <= TapW'(TapCnt - 1))
    else $error("tap count out of range");
  a_border_skip: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StUpd && !stat_i.interior) |=> state_q == StIdle)
    else $error("border pixel not dropped");
  a_div_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StDiv && div_q == DivCntW'(DivSteps)) |=> state_q == StOut)
    else $error("divide did not finish");
`endif
endmodule
`default_nettype wire

// ===== sv/rcnf_dp.sv =====
// Datapath: position counters, line stores, window, MAC, three serial dividers, output reg.
`default_nettype none
module rcnf_dp import rcnf_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  cmd_t             cmd_i,
  output stat_t            stat_o,
  input  logic             in_valid_i,
  input  logic [23:0]      pix_i,
  input  logic [71:0]      kern_i,
  input  logic [15:0]      divisor_i,
  input  logic [SizeW-1:0] width_i,
  input  logic [SizeW-1:0] height_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic [47:0]      out_data_o,
  output logic             out_last_o
);
  logic [23:0] line_a [MaxWidth];
  logic [23:0] line_b [MaxWidth];
  logic [23:0] rd_a_q, rd_b_q, pix_q;
  logic [23:0] win_q [6];
  logic [23:0] tap_q [TapCnt];
  logic [AddrW-1:0] col_q, row_q, c_q, r_q;
  logic last_q;

  // position of the arriving pixel
  logic [SizeW-1:0] c0, r0, r1, cn, rn;
  always_comb begin
    c0 = {1'b0, col_q};
    r0 = {1'b0, row_q};
    if (c0 >= width_i) begin
      c0 = '0;
      r0 = r0 + 1'b1;
    end
    if (r0 >= height_i) r0 = '0;
    cn = c0 + 1'b1;
    rn = r0 + 1'b1;
    r1 = (rn >= height_i) ? '0 : rn;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
      for (int k = 0; k < 6; k++) win_q[k] <= '0;
    end else begin
      if (cmd_i.capture && in_valid_i) begin
        if (cn >= width_i) begin
          col_q <= '0;
          row_q <= r1[AddrW-1:0];
        end else begin
          col_q <= cn[AddrW-1:0];
          row_q <= r0[AddrW-1:0];
        end
      end
      if (cmd_i.update) begin
        win_q[0] <= pix_q;  win_q[1] <= rd_a_q; win_q[2] <= rd_b_q;
        win_q[3] <= win_q[0]; win_q[4] <= win_q[1]; win_q[5] <= win_q[2];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture && in_valid_i) begin
      pix_q  <= pix_i;
      c_q    <= c0[AddrW-1:0];
      r_q    <= r0[AddrW-1:0];
      last_q <= (r0 == height_i - 1'b1) && (c0 == width_i - 1'b1);
    end
    if (cmd_i.mem_rd) begin
      rd_a_q <= line_a[c_q];
      rd_b_q <= line_b[c_q];
    end
    if (cmd_i.update) begin
      line_a[c_q] <= pix_q;
      line_b[c_q] <= rd_a_q;
      // index = kernel row * 3 + kernel column
      tap_q[0] <= pix_q;  tap_q[1] <= win_q[0]; tap_q[2] <= win_q[3];
      tap_q[3] <= rd_a_q; tap_q[4] <= win_q[1]; tap_q[5] <= win_q[4];
      tap_q[6] <= rd_b_q; tap_q[7] <= win_q[2]; tap_q[8] <= win_q[5];
    end
  end

  assign stat_o.interior = (r_q >= AddrW'(2)) && (c_q >= AddrW'(2));

  // tap-serial multiply-accumulate, one tap per cycle for all three channels
  logic signed [SumW-1:0]       acc_q [3];
  logic signed [CoefBits-1:0]   coef;
  logic signed [CoefBits+8:0]   prod [3];
  assign coef = kern_i[cmd_i.tap * CoefBits +: CoefBits];
  always_comb begin
    for (int ch = 0; ch < 3; ch++)
      prod[ch] = $signed({1'b0, tap_q[cmd_i.tap][8*ch +: 8]}) * coef;
  end

  // restoring dividers: step 0 loads, steps 1..DivSteps produce one quotient bit each
  logic [15:0]         dv;
  logic [15:0]         rem_q [3];
  logic [DivSteps-1:0] dq_q [3];
  logic                neg_q [3];
  logic [16:0]         trial [3];
  assign dv = (divisor_i == '0) ? 16'd1 : divisor_i;
  always_comb begin
    for (int ch = 0; ch < 3; ch++) trial[ch] = {rem_q[ch], dq_q[ch][DivSteps-1]};
  end

  always_ff @(posedge clk_i) begin
    for (int ch = 0; ch < 3; ch++) begin
      if (cmd_i.update) acc_q[ch] <= '0;
      else if (cmd_i.mac_en) acc_q[ch] <= acc_q[ch] + SumW'(prod[ch]);
      if (cmd_i.div_en) begin
        if (cmd_i.div_step == '0) begin
          dq_q[ch]  <= acc_q[ch][DivSteps-1:0];
          neg_q[ch] <= acc_q[ch][SumW-1];
          rem_q[ch] <= '0;
        end else if (trial[ch] >= {1'b0, dv}) begin
          rem_q[ch] <= 16'(trial[ch] - {1'b0, dv});
          dq_q[ch]  <= {dq_q[ch][DivSteps-2:0], 1'b1};
        end else begin
          rem_q[ch] <= trial[ch][15:0];
          dq_q[ch]  <= {dq_q[ch][DivSteps-2:0], 1'b0};
        end
      end
    end
  end

  logic [7:0] sat [3];
  always_comb begin
    for (int ch = 0; ch < 3; ch++) begin
      if (neg_q[ch])               sat[ch] = 8'd0;
      else if (|dq_q[ch][DivSteps-1:8]) sat[ch] = 8'hFF;
      else                         sat[ch] = dq_q[ch][7:0];
    end
  end

  // output register
  assign stat_o.out_free = !out_valid_o || out_ready_i;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) out_valid_o <= 1'b0;
    else if (cmd_i.load_out) out_valid_o <= 1'b1;
    else if (out_ready_i) out_valid_o <= 1'b0;
  end
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      out_data_o <= {4'd0, c_q - 1'b1, r_q - 1'b1, sat[2], sat[1], sat[0]};
      out_last_o <= last_q;
    end
  end
endmodule
`default_nettype wire
